FILE: rtl/bms_pkg.sv
// Shared types and constants of the bracket match stack.
`timescale 1ns / 1ps

package bms_pkg;

   localparam int BMS_STACK_DEPTH = 64;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [2:0] STATUS_IGNORED   = 3'd0;
   localparam logic [2:0] STATUS_PUSHED    = 3'd1;
   localparam logic [2:0] STATUS_MATCHED   = 3'd2;
   localparam logic [2:0] STATUS_UNMATCHED = 3'd3;
   localparam logic [2:0] STATUS_UNCLOSED  = 3'd4;
   localparam logic [2:0] STATUS_CLEAN     = 3'd5;

   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_CURLY  = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;

   // One stack entry as held by a cell.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

FILE: rtl/bracket_match_stack_unit.sv
// Top level of the bracket match stack: control, result register and cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Carries
// req_      in         req_valid / req_ready  command, char_code, line, column
// rsp_      out        rsp_valid / rsp_ready  status, kind, line, column, flags, last
//
// A character item's single result is ready in the cycle after the item is
// taken; with rsp_ready held high one character item is accepted every cycle.
// An end-of-input item on an empty stack gives its result the next cycle. On a
// non-empty stack the cell chain shifts toward the deep end once per cycle,
// holding while an occupied deepest cell waits for the result register, and
// each entry is reported as it leaves the deepest cell; no item is accepted
// meanwhile. Reset is synchronous and empties the stack at once.

module bracket_match_stack_unit
   import bms_pkg::*;
#(
   parameter int STACK_DEPTH = BMS_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_char_code,
   input  logic [15:0] req_line,
   input  logic [15:0] req_column,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_bracket_kind,
   output logic [15:0] rsp_report_line,
   output logic [15:0] rsp_report_column,
   output logic        rsp_overflow,
   output logic        rsp_syntax_error,
   output logic        rsp_last
);

   // Cell 0 is the top of the stack; occupied cells form a run from cell 0
   // while idle. The deepest cell is where the end-of-input report reads.
   entry_type   cells [STACK_DEPTH];
   entry_type   head_entry;
   entry_type   empty_entry;
   cell_op_type cell_op;

   state_type state_ff;
   state_type state_in;

   logic        error_flag_ff;
   logic        error_flag_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [2:0]  rsp_status_in;
   logic [1:0]  rsp_kind_ff;
   logic [1:0]  rsp_kind_in;
   logic [15:0] rsp_line_ff;
   logic [15:0] rsp_line_in;
   logic [15:0] rsp_column_ff;
   logic [15:0] rsp_column_in;
   logic        rsp_overflow_ff;
   logic        rsp_overflow_in;
   logic        rsp_syntax_ff;
   logic        rsp_syntax_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;
   logic        load_rsp;

   logic        out_free;
   logic        accept;
   logic        is_open;
   logic        is_close;
   logic [1:0]  dec_kind;
   logic [15:0] column_plus_one;
   logic        stack_full;
   logic        top_match;
   logic        drain_emit;
   logic        drain_done;

   assign empty_entry = '0;

   // The result register may be reloaded in the cycle its transfer completes.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign column_plus_one = req_column + 16'd1;
   assign stack_full      = cells[STACK_DEPTH-1].valid;
   assign top_match       = cells[0].valid && (cells[0].kind == dec_kind);

   // While draining, the deepest cell is reported once the result register
   // is free; it is the last one when the cell above it is already empty.
   assign drain_emit = cells[STACK_DEPTH-1].valid && out_free;
   assign drain_done = drain_emit && !cells[STACK_DEPTH-2].valid;

   always_comb begin
      is_open  = 1'b0;
      is_close = 1'b0;
      dec_kind = KIND_ROUND;
      case (req_char_code)
         CHAR_ROUND_OPEN: begin
            is_open  = 1'b1;
            dec_kind = KIND_ROUND;
         end
         CHAR_ROUND_CLOSE: begin
            is_close = 1'b1;
            dec_kind = KIND_ROUND;
         end
         CHAR_CURLY_OPEN: begin
            is_open  = 1'b1;
            dec_kind = KIND_CURLY;
         end
         CHAR_CURLY_CLOSE: begin
            is_close = 1'b1;
            dec_kind = KIND_CURLY;
         end
         CHAR_SQUARE_OPEN: begin
            is_open  = 1'b1;
            dec_kind = KIND_SQUARE;
         end
         CHAR_SQUARE_CLOSE: begin
            is_close = 1'b1;
            dec_kind = KIND_SQUARE;
         end
         default: begin
            is_open  = 1'b0;
            is_close = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_END) && cells[0].valid) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller: chain operation, result load and flag update.
   always_comb begin
      cell_op         = CELL_HOLD;
      head_entry      = empty_entry;
      load_rsp        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_line_in     = rsp_line_ff;
      rsp_column_in   = rsp_column_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_syntax_in   = rsp_syntax_ff;
      rsp_last_in     = rsp_last_ff;
      error_flag_in   = error_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_rsp        = 1'b1;
               rsp_kind_in     = dec_kind;
               rsp_line_in     = req_line;
               rsp_column_in   = column_plus_one;
               rsp_overflow_in = 1'b0;
               rsp_syntax_in   = error_flag_ff;
               rsp_last_in     = 1'b1;
               if (req_command == CMD_END) begin
                  // A non-empty stack is reported from the drain state instead.
                  load_rsp      = !cells[0].valid;
                  rsp_status_in = STATUS_CLEAN;
                  rsp_kind_in   = KIND_ROUND;
                  rsp_line_in   = '0;
                  rsp_column_in = '0;
                  if (!cells[0].valid) begin
                     error_flag_in = 1'b0;
                  end
               end else if (is_open) begin
                  rsp_status_in   = STATUS_PUSHED;
                  rsp_overflow_in = stack_full;
                  if (!stack_full) begin
                     cell_op    = CELL_SHIFT_DOWN;
                     head_entry = '{valid: 1'b1, kind: dec_kind, line: req_line,
                                    column: column_plus_one};
                  end
               end else if (is_close) begin
                  if (top_match) begin
                     rsp_status_in = STATUS_MATCHED;
                     cell_op       = CELL_SHIFT_UP;
                  end else begin
                     rsp_status_in = STATUS_UNMATCHED;
                     rsp_syntax_in = 1'b1;
                     error_flag_in = 1'b1;
                  end
               end else begin
                  rsp_status_in = STATUS_IGNORED;
                  rsp_kind_in   = KIND_ROUND;
                  rsp_line_in   = '0;
                  rsp_column_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            // Empty deep cells are skipped by shifting; an occupied deepest
            // cell waits until the result register can take it.
            if (!cells[STACK_DEPTH-1].valid || drain_emit) begin
               cell_op = CELL_SHIFT_DOWN;
            end
            if (drain_emit) begin
               load_rsp        = 1'b1;
               rsp_status_in   = STATUS_UNCLOSED;
               rsp_kind_in     = cells[STACK_DEPTH-1].kind;
               rsp_line_in     = cells[STACK_DEPTH-1].line;
               rsp_column_in   = cells[STACK_DEPTH-1].column;
               rsp_overflow_in = 1'b0;
               rsp_syntax_in   = error_flag_ff;
               rsp_last_in     = drain_done;
            end
            if (drain_done) begin
               error_flag_in = 1'b0;
            end
         end
         default: begin
            cell_op = CELL_HOLD;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         error_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         error_flag_ff <= error_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_line_ff     <= rsp_line_in;
      rsp_column_ff   <= rsp_column_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_syntax_ff   <= rsp_syntax_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // The cell chain. All cells share one operation; the ends are fed the new
   // entry at the top and an empty entry at the deep end.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_top
         assign prev_entry = head_entry;
      end else begin : g_mid_prev
         assign prev_entry = cells[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign next_entry = empty_entry;
      end else begin : g_mid_next
         assign next_entry = cells[i+1];
      end

      bms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_op    (cell_op),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cells[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bracket_kind  = rsp_kind_ff;
   assign rsp_report_line   = rsp_line_ff;
   assign rsp_report_column = rsp_column_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_syntax_error  = rsp_syntax_ff;
   assign rsp_last          = rsp_last_ff;

   // While idle, any held entry implies the top cell is held too.
   a_top_filled_first : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && cells[1].valid |-> cells[0].valid)
      else $error("stack entries are not packed against the top cell");

   // End of input on a non-empty stack starts the drain.
   a_drain_starts : assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_END) && cells[0].valid |=> (state_ff == ST_DRAIN))
      else $error("end of input on a non-empty stack did not start the drain");

   // Leaving the drain leaves an empty stack and a clear error flag.
   a_drain_clears : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && ($past(state_ff) == ST_DRAIN)
      |-> !error_flag_ff && !cells[0].valid && !cells[STACK_DEPTH-1].valid)
      else $error("drain ended with entries or the error flag left over");

   // A push never lands on a full chain.
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && (cell_op == CELL_SHIFT_DOWN) |-> !stack_full)
      else $error("push shifted an entry out of the deepest cell");

endmodule

FILE: rtl/bms_cell.sv
// One cell of the stack chain: holds one entry and moves it to a neighbor.
`timescale 1ns / 1ps

module bms_cell
   import bms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type cell_op,
   input  entry_type   prev_entry,
   input  entry_type   next_entry,
   output entry_type   entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Shift down takes the entry nearer the top; shift up takes the deeper one.
   always_comb begin
      case (cell_op)
         CELL_SHIFT_DOWN: entry_in = prev_entry;
         CELL_SHIFT_UP:   entry_in = next_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the bracket match stack unit.
`timescale 1ns / 1ps

module tb_top;
   import bms_pkg::*;

   // One result transfer, packed so that an expectation compares in a single step.
   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic        overflow;
      logic        syntax_error;
      logic        last;
   } bracket_result_type;

   // One row of the directed table. Rows with typed set carry their expected
   // result; all other rows take their expectation from the bracket tracker.
   typedef struct packed {
      logic               command;
      logic [7:0]         char_code;
      logic [15:0]        line;
      logic [15:0]        column;
      logic               typed;
      bracket_result_type result;
   } directed_row_type;

   localparam bracket_result_type UNTYPED = '0;
   localparam logic [7:0] CHAR_LETTER_A = 8'h41;
   localparam logic [7:0] CHAR_HIGH_BIT = 8'h80;
   localparam int NUM_DIRECTED = 22;
   localparam int ITEM_TARGET = 410;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_TWO_START = 140;
   localparam int PHASE_THREE_START = 275;

   // The directed table walks from an empty stack through every status code.
   // An ignored byte reports kind, line and column as zero, so KIND_ROUND
   // stands for the zero kind in those rows.
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // End of input straight after reset: one clean result, flag still clear.
      '{CMD_END, 8'h00, 16'h0000, 16'h0000, 1'b1,
        '{STATUS_CLEAN, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}},
      // Bytes that are not brackets, at both extremes of every field.
      '{CMD_CHAR, CHAR_LETTER_A, 16'h0000, 16'h0000, 1'b1,
        '{STATUS_IGNORED, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}},
      '{CMD_CHAR, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1,
        '{STATUS_IGNORED, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}},
      '{CMD_CHAR, 8'hFF, 16'h5555, 16'hAAAA, 1'b1,
        '{STATUS_IGNORED, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}},
      // Closing brackets on an empty stack; the flag reads set on the same result.
      '{CMD_CHAR, CHAR_ROUND_CLOSE, 16'h0000, 16'h0000, 1'b1,
        '{STATUS_UNMATCHED, KIND_ROUND, 16'h0000, 16'h0001, 1'b0, 1'b1, 1'b1}},
      '{CMD_CHAR, CHAR_CURLY_CLOSE, 16'hFFFF, 16'hFFFE, 1'b1,
        '{STATUS_UNMATCHED, KIND_CURLY, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1}},
      // The one-based column wraps to zero at the top of the range.
      '{CMD_CHAR, CHAR_SQUARE_CLOSE, 16'h1234, 16'hFFFF, 1'b1,
        '{STATUS_UNMATCHED, KIND_SQUARE, 16'h1234, 16'h0000, 1'b0, 1'b1, 1'b1}},
      // The clean result still shows the flag, which clears afterwards.
      '{CMD_END, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
        '{STATUS_CLEAN, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1}},
      // Nesting with matched pops, a mismatch and an ignored byte.
      '{CMD_CHAR, CHAR_ROUND_OPEN, 16'h0001, 16'h0000, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_CURLY_OPEN, 16'h0002, 16'h0005, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_SQUARE_OPEN, 16'hFFFF, 16'hFFFF, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_SQUARE_CLOSE, 16'h0003, 16'hAAAA, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_ROUND_CLOSE, 16'h0004, 16'h5555, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_CURLY_CLOSE, 16'h0005, 16'h0000, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_HIGH_BIT, 16'h0006, 16'h0001, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_ROUND_CLOSE, 16'h0007, 16'h0002, 1'b0, UNTYPED},
      // Two brackets left open, then reported with the flag still set.
      '{CMD_CHAR, CHAR_SQUARE_OPEN, 16'h0008, 16'hFFFE, 1'b0, UNTYPED},
      '{CMD_CHAR, CHAR_ROUND_OPEN, 16'h0009, 16'h0007, 1'b0, UNTYPED},
      '{CMD_END, 8'h00, 16'h0000, 16'h0000, 1'b0, UNTYPED},
      // A single unclosed bracket with the flag clear, then an empty report.
      '{CMD_CHAR, CHAR_CURLY_OPEN, 16'hAAAA, 16'h5555, 1'b0, UNTYPED},
      '{CMD_END, 8'h00, 16'h0000, 16'h0000, 1'b0, UNTYPED},
      '{CMD_END, 8'h00, 16'h0000, 16'h0000, 1'b1,
        '{STATUS_CLEAN, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_CHAR;
   logic [7:0]  req_char_code = 8'h00;
   logic [15:0] req_line = 16'h0000;
   logic [15:0] req_column = 16'h0000;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_bracket_kind;
   logic [15:0] rsp_report_line;
   logic [15:0] rsp_report_column;
   logic        rsp_overflow;
   logic        rsp_syntax_error;
   logic        rsp_last;

   // Shadow copy of the bracket stack and the sticky error flag.
   logic [1:0]  held_kind [BMS_STACK_DEPTH];
   logic [15:0] held_line [BMS_STACK_DEPTH];
   logic [15:0] held_column [BMS_STACK_DEPTH];
   int          held = 0;
   logic        sticky_error = 1'b0;

   // Results of the item just accepted, and all results still to arrive in order.
   bracket_result_type step_results [$];
   bracket_result_type awaited_results [$];

   int tx_idle_pct = 35;
   int rx_stall_pct = 53;
   int bracket_items = 0;
   int failures = 0;
   int quiet_cycles = 0;

   bracket_match_stack_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_char_code     (req_char_code),
      .req_line          (req_line),
      .req_column        (req_column),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_bracket_kind  (rsp_bracket_kind),
      .rsp_report_line   (rsp_report_line),
      .rsp_report_column (rsp_report_column),
      .rsp_overflow      (rsp_overflow),
      .rsp_syntax_error  (rsp_syntax_error),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the results of one accepted item and advances the shadow stack.
   // Every result carries the flag as it stands once the item has been seen,
   // so an unmatched close already shows it set and a report shows it before
   // the clear.
   function automatic void track_brackets(input logic command, input logic [7:0] char_code,
                                          input logic [15:0] line, input logic [15:0] column);
      bracket_result_type r;
      logic [15:0]        column_one;
      logic [1:0]         kind;
      logic               opening;
      logic               is_bracket;
      step_results.delete();
      column_one = column + 16'd1;
      if (command == CMD_END) begin
         if (held == 0) begin
            r = '{STATUS_CLEAN, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, sticky_error, 1'b1};
            step_results.push_back(r);
         end
         // Open brackets are reported from the bottom of the stack upward.
         for (int i = 0; i < held; i++) begin
            r = '{STATUS_UNCLOSED, held_kind[i], held_line[i], held_column[i], 1'b0,
                  sticky_error, (i == held - 1)};
            step_results.push_back(r);
         end
         held = 0;
         sticky_error = 1'b0;
         return;
      end
      is_bracket = 1'b1;
      opening = 1'b0;
      kind = KIND_ROUND;
      case (char_code)
         CHAR_ROUND_OPEN: begin
            kind = KIND_ROUND;
            opening = 1'b1;
         end
         CHAR_ROUND_CLOSE: kind = KIND_ROUND;
         CHAR_CURLY_OPEN: begin
            kind = KIND_CURLY;
            opening = 1'b1;
         end
         CHAR_CURLY_CLOSE: kind = KIND_CURLY;
         CHAR_SQUARE_OPEN: begin
            kind = KIND_SQUARE;
            opening = 1'b1;
         end
         CHAR_SQUARE_CLOSE: kind = KIND_SQUARE;
         default: is_bracket = 1'b0;
      endcase
      if (!is_bracket) begin
         r = '{STATUS_IGNORED, KIND_ROUND, 16'h0000, 16'h0000, 1'b0, sticky_error, 1'b1};
      end else if (opening) begin
         // A push onto a full stack is dropped but still reported.
         if (held >= BMS_STACK_DEPTH) begin
            r = '{STATUS_PUSHED, kind, line, column_one, 1'b1, sticky_error, 1'b1};
         end else begin
            held_kind[held] = kind;
            held_line[held] = line;
            held_column[held] = column_one;
            held++;
            r = '{STATUS_PUSHED, kind, line, column_one, 1'b0, sticky_error, 1'b1};
         end
      end else if (held == 0 || held_kind[held - 1] != kind) begin
         sticky_error = 1'b1;
         r = '{STATUS_UNMATCHED, kind, line, column_one, 1'b0, sticky_error, 1'b1};
      end else begin
         held--;
         r = '{STATUS_MATCHED, kind, line, column_one, 1'b0, sticky_error, 1'b1};
      end
      step_results.push_back(r);
   endfunction

   function automatic logic [7:0] open_char(input logic [1:0] kind);
      case (kind)
         KIND_CURLY:  return CHAR_CURLY_OPEN;
         KIND_SQUARE: return CHAR_SQUARE_OPEN;
         default:     return CHAR_ROUND_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input logic [1:0] kind);
      case (kind)
         KIND_CURLY:  return CHAR_CURLY_CLOSE;
         KIND_SQUARE: return CHAR_SQUARE_CLOSE;
         default:     return CHAR_ROUND_CLOSE;
      endcase
   endfunction

   // Mostly random positions, with the ends of the range now and then.
   function automatic logic [15:0] random_position();
      case ($urandom_range(0, 15))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic string show_result(input bracket_result_type r);
      return $sformatf("status %0d kind %0d line %h column %h overflow %b error %b last %b",
                       r.status, r.kind, r.line, r.column, r.overflow, r.syntax_error, r.last);
   endfunction

   // Offers one item on the request channel and holds it until the transfer.
   // The caller stands at a rising edge; valid is only lowered while idling,
   // so it never gets two assignments in one time step.
   task automatic send_item(input logic command, input logic [7:0] char_code,
                            input logic [15:0] line, input logic [15:0] column,
                            input logic typed, input bracket_result_type typed_result);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= command;
      req_char_code <= char_code;
      req_line      <= line;
      req_column    <= column;
      do @(posedge clock); while (!req_ready);
      // The transfer happens at this edge.
      track_brackets(command, char_code, line, column);
      if (typed) begin
         awaited_results.push_back(typed_result);
      end else begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
      bracket_items++;
   endtask

   task automatic send_char(input logic [7:0] char_code);
      send_item(CMD_CHAR, char_code, random_position(), random_position(), 1'b0, UNTYPED);
   endtask

   task automatic send_end();
      send_item(CMD_END, 8'($urandom_range(0, 255)), random_position(), random_position(),
                1'b0, UNTYPED);
   endtask

   // Stops offering items until every awaited result has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // A text of random nesting: opens and correct closes, with a
   // few stray bytes and wrong closes mixed in, often closed fully before the end.
   task automatic nested_document();
      int          steps;
      int          r;
      logic [1:0]  top;
      steps = $urandom_range(4, 40);
      repeat (steps) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_char(8'($urandom_range(0, 255)));
         end else if (r < 12) begin
            if (held == 0) begin
               send_char(close_char(2'($urandom_range(0, 2))));
            end else begin
               top = held_kind[held - 1];
               send_char(close_char(top == KIND_SQUARE ? KIND_ROUND : top + 2'd1));
            end
         end else if ((held == 0 || r < 55) && held < BMS_STACK_DEPTH) begin
            send_char(open_char(2'($urandom_range(0, 2))));
         end else if (held > 0) begin
            send_char(close_char(held_kind[held - 1]));
         end else begin
            send_char(open_char(2'($urandom_range(0, 2))));
         end
      end
      if ($urandom_range(0, 1) == 0) begin
         while (held > 0) send_char(close_char(held_kind[held - 1]));
      end
      send_end();
   endtask

   // Fills the stack near, to or past its depth so that pushes may overflow, then
   // reports a long list of unclosed brackets.
   task automatic deep_document(input int opens);
      repeat (opens) send_char(open_char(2'($urandom_range(0, 2))));
      repeat ($urandom_range(0, 10)) begin
         if (held > 0) send_char(close_char(held_kind[held - 1]));
      end
      send_end();
   endtask

   // Random bytes, half of them brackets of any kind and direction.
   task automatic noise_document();
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 1) == 0) begin
            send_char(8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 1) == 0) begin
            send_char(open_char(2'($urandom_range(0, 2))));
         end else begin
            send_char(close_char(2'($urandom_range(0, 2))));
         end
      end
      send_end();
   endtask

   // The receiver stalls at random with the share that the current phase sets.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // Every result transfer is checked against the oldest awaited result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bracket_result_type got;
         got = '{rsp_status, rsp_bracket_kind, rsp_report_line, rsp_report_column,
                 rsp_overflow, rsp_syntax_error, rsp_last};
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: result with nothing awaited: %s", $realtime, show_result(got));
            end
         end else if (got !== awaited_results[0]) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected %s", show_result(awaited_results[0]));
               $display("   actual   %s", show_result(got));
            end
            void'(awaited_results.pop_front());
         end else begin
            void'(awaited_results.pop_front());
         end
      end
   end

   // Watchdog: a report on a nearly empty stack first shifts its entry across
   // nearly the whole chain, and the receiver may stall on top of that, so the
   // limit sits well above either.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int docs;
      int deep_docs;
      int phase;
      int r;
      docs = 0;
      deep_docs = 0;
      phase = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < NUM_DIRECTED; row++) begin
         send_item(DIRECTED_ROWS[row].command, DIRECTED_ROWS[row].char_code,
                   DIRECTED_ROWS[row].line, DIRECTED_ROWS[row].column,
                   DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].result);
      end
      wait_until_drained();

      // Random texts. The sender and the receiver swap their idle shares at
      // PHASE_TWO_START items, and from PHASE_THREE_START items on both run at full rate.
      // Each phase change waits for the block to drain first.
      while (bracket_items < ITEM_TARGET) begin
         if (phase == 1 && bracket_items >= PHASE_TWO_START) begin
            wait_until_drained();
            tx_idle_pct = 53;
            rx_stall_pct = 35;
            phase = 2;
         end else if (phase == 2 && bracket_items >= PHASE_THREE_START) begin
            wait_until_drained();
            tx_idle_pct = 0;
            rx_stall_pct = 0;
            phase = 3;
         end
         r = $urandom_range(0, 99);
         if (docs == 0) begin
            // The first text pushes past the depth so that overflow always shows.
            deep_document(BMS_STACK_DEPTH + 2);
            deep_docs++;
         end else if (r >= 72 && r < 80 && deep_docs < 3) begin
            deep_document($urandom_range(BMS_STACK_DEPTH - 4, BMS_STACK_DEPTH + 4));
            deep_docs++;
         end else if (r < 80) begin
            nested_document();
         end else begin
            noise_document();
         end
         docs++;
      end

      wait_until_drained();
      // Anything the block sends after the last awaited result is a failure.
      repeat (BMS_STACK_DEPTH + 8) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
